[hw/rtl/sha1v_pkg.sv]
// ----------------------------------------------------------------------------
// sha1v_pkg
// shared types, codes and constants of the sha1 variant digest block
// ----------------------------------------------------------------------------
package sha1v_pkg;

   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_INIT,
      ST_RD,
      ST_EXE,
      ST_FIN,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // what follows the running compression
   typedef enum logic [1:0] {
      PEND_ACCEPT,
      PEND_PAD_MARK,
      PEND_PAD_LEN,
      PEND_EMIT
   } pend_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_FIRST,
      RD_SECOND
   } rd_sel_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      logic [3:0] rd_idx;
      logic       cap_x;
      logic       exe;
      logic [3:0] w_idx;
      logic       w_sched;
      logic       ext_we;
      logic [3:0] ext_addr;
      word_type   ext_data;
   } wm_ctl_type;

   typedef struct packed {
      logic       load_iv;
      logic       init;
      logic       exe;
      logic [6:0] round;
      logic       fin;
      logic       chk;
      logic [2:0] chk_idx;
      logic [2:0] out_idx;
   } core_ctl_type;

   localparam word_type K_ROUND0 = 32'hd8f7_b6a3;
   localparam word_type K_ROUND1 = 32'h146e_79fc;
   localparam word_type K_ROUND2 = 32'h3f08_a342;
   localparam word_type K_ROUND3 = 32'he8c1_68aa;

   localparam word_type IV0_RESET = 32'h545f_7702;
   localparam word_type IV1_RESET = 32'hcb19_042b;
   localparam word_type IV2_RESET = 32'hdb8d_ca18;
   localparam word_type IV3_RESET = 32'h28b2_b375;
   localparam word_type IV4_RESET = 32'hf237_21ad;
   localparam logic [7:0] DIFF_RESET = 8'd0;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [2:0] CSR_IV0  = 3'd0;
   localparam logic [2:0] CSR_IV1  = 3'd1;
   localparam logic [2:0] CSR_IV2  = 3'd2;
   localparam logic [2:0] CSR_IV3  = 3'd3;
   localparam logic [2:0] CSR_IV4  = 3'd4;
   localparam logic [2:0] CSR_DIFF = 3'd5;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [6:0] SCHED_START = 7'd16;
   localparam logic [2:0] LAST_WORD = 3'd4;
   localparam logic [3:0] LAST_SLOT = 4'd15;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LEN_LIMIT = 6'd56;
   localparam logic [1:0] LAST_LANE = 2'd3;

endpackage

[hw/rtl/sha1v_wmem.sv]
// ----------------------------------------------------------------------------
// sha1v_wmem
// 16-word block and message schedule memory, two registered read ports,
// one write port, schedule word generation over two reads per round
// ----------------------------------------------------------------------------
module sha1v_wmem (
   input  logic                  clock,
   input  sha1v_pkg::wm_ctl_type ctl,
   output sha1v_pkg::word_type   w
);
   import sha1v_pkg::*;

   word_type   mem_ff [16];
   word_type   rda_ff;
   word_type   rdb_ff;
   word_type   x_ff;
   word_type   x_in;
   word_type   mix;
   word_type   wdata;
   logic       we;
   logic [3:0] waddr;
   logic [3:0] ra;
   logic [3:0] rb;

   // first read: w[j-8], w[j-14]; second read: w[j-16], w[j-3]
   always_comb begin
      case (ctl.rd_sel)
         RD_FIRST: begin
            ra = ctl.rd_idx + 4'd8;
            rb = ctl.rd_idx + 4'd2;
         end
         RD_SECOND: begin
            ra = ctl.rd_idx;
            rb = ctl.rd_idx + 4'd13;
         end
         default: begin
            ra = ctl.rd_idx;
            rb = ctl.rd_idx;
         end
      endcase
   end

   always_comb begin
      mix   = x_ff ^ rda_ff ^ rdb_ff;
      w     = ctl.w_sched ? {mix[30:0], mix[31]} : rda_ff;
      x_in  = ctl.cap_x ? (rda_ff ^ rdb_ff) : x_ff;
      we    = ctl.exe | ctl.ext_we;
      waddr = ctl.exe ? ctl.w_idx : ctl.ext_addr;
      wdata = ctl.exe ? w : ctl.ext_data;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rda_ff <= mem_ff[ra];
      rdb_ff <= mem_ff[rb];
      x_ff   <= x_in;
   end

endmodule

[hw/rtl/sha1v_core.sv]
// ----------------------------------------------------------------------------
// sha1v_core
// working variables, round function, chaining words and difficulty check
// ----------------------------------------------------------------------------
module sha1v_core (
   input  logic                      clock,
   input  sha1v_pkg::core_ctl_type   ctl,
   input  sha1v_pkg::word_type [4:0] iv,
   input  logic [7:0]                difficulty,
   input  sha1v_pkg::word_type       w,
   output sha1v_pkg::word_type       out_word,
   output logic                      flag
);
   import sha1v_pkg::*;

   word_type [4:0] chain_ff;
   word_type [4:0] chain_in;
   word_type       a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type       a_in, b_in, c_in, d_in, e_in;
   word_type       f;
   word_type       k;
   word_type       t;
   word_type       chk_word;
   logic           flag_ff;
   logic           flag_in;
   logic           bad;
   logic [7:0]     bit_pos;

   always_comb begin
      if (ctl.round < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K_ROUND0;
      end else if (ctl.round < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K_ROUND1;
      end else if (ctl.round < 7'd60) begin
         f = (d_ff & c_ff) | (b_ff & (d_ff | c_ff));
         k = K_ROUND2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K_ROUND3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + e_ff + w + f + k;
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctl.init) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (ctl.exe) begin
         a_in = t;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctl.load_iv) begin
         chain_in = iv;
      end else if (ctl.fin) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   // digest bit order: bytes low first, each byte msb first
   always_comb begin
      chk_word = chain_ff[ctl.chk_idx];
      bad      = 1'b0;
      bit_pos  = 8'd0;
      for (int j = 0; j < 4; j++) begin
         for (int b = 0; b < 8; b++) begin
            bit_pos = {ctl.chk_idx, 5'd0} + 8'(8 * j + 7 - b);
            if (chk_word[8 * j + b] && (bit_pos < difficulty)) begin
               bad = 1'b1;
            end
         end
      end
      flag_in = flag_ff;
      if (ctl.chk) begin
         flag_in = ((ctl.chk_idx == 3'd0) ? 1'b1 : flag_ff) & ~bad;
      end
   end

   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      flag_ff  <= flag_in;
   end

   assign out_word = chain_ff[ctl.out_idx];
   assign flag     = flag_ff;

endmodule

[hw/rtl/sha1v_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1v_ctrl
// sequencer: byte packing, padding, round stepping, check and result output
// ----------------------------------------------------------------------------
module sha1v_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              in_data,
   input  logic                    in_last,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2:0]              out_index,
   output logic                    out_last,
   output sha1v_pkg::wm_ctl_type   wm_ctl,
   output sha1v_pkg::core_ctl_type core_ctl
);
   import sha1v_pkg::*;

   state_type   state_ff, state_in;
   pend_type    pend_ff, pend_in;
   logic [28:0] cnt_ff, cnt_in;
   word_type    acc_ff, acc_in;
   logic        open_ff, open_in;
   logic [3:0]  pad_idx_ff, pad_idx_in;
   logic        mark_ff, mark_in;
   logic        len_ff, len_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;

   logic [28:0] cnt_inc;
   logic [1:0]  lane;
   logic [5:0]  pos;
   logic [5:0]  rem;
   word_type    keep;
   word_type    word_new;
   word_type    marker;
   word_type    bits;

   always_comb begin
      lane     = cnt_ff[1:0];
      pos      = cnt_ff[5:0];
      cnt_inc  = cnt_ff + 29'd1;
      rem      = cnt_inc[5:0];
      keep     = ~(32'hffff_ffff >> {lane, 3'b000});
      word_new = (acc_ff & keep) | (word_type'(in_data) << (5'd24 - {lane, 3'b000}));
      marker   = (acc_ff & keep) | (word_type'(PAD_BYTE) << (5'd24 - {lane, 3'b000}));
      bits     = {cnt_ff, 3'b000};
   end

   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      open_in    = open_ff;
      pad_idx_in = pad_idx_ff;
      mark_in    = mark_ff;
      len_in     = len_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;

      in_ready  = 1'b0;
      out_valid = 1'b0;

      wm_ctl          = '0;
      wm_ctl.rd_sel   = RD_NONE;
      core_ctl        = '0;
      core_ctl.round   = round_ff;
      core_ctl.chk_idx = idx_ff;
      core_ctl.out_idx = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               core_ctl.load_iv = ~open_ff;
               open_in = 1'b1;
               cnt_in  = cnt_inc;
               acc_in  = word_new;
               if (lane == LAST_LANE) begin
                  wm_ctl.ext_we   = 1'b1;
                  wm_ctl.ext_addr = pos[5:2];
                  wm_ctl.ext_data = word_new;
               end
               if (!in_last) begin
                  if (pos == LAST_POS) begin
                     pend_in  = PEND_ACCEPT;
                     state_in = ST_INIT;
                  end
               end else if (rem == 6'd0) begin
                  pend_in  = PEND_PAD_MARK;
                  state_in = ST_INIT;
               end else begin
                  pad_idx_in = rem[5:2];
                  mark_in    = 1'b1;
                  len_in     = (rem <= LEN_LIMIT);
                  pend_in    = (rem <= LEN_LIMIT) ? PEND_EMIT : PEND_PAD_LEN;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wm_ctl.ext_we   = 1'b1;
            wm_ctl.ext_addr = pad_idx_ff;
            if (mark_ff) begin
               wm_ctl.ext_data = marker;
            end else if (len_ff && (pad_idx_ff == LAST_SLOT)) begin
               wm_ctl.ext_data = bits;
            end else begin
               wm_ctl.ext_data = '0;
            end
            mark_in = 1'b0;
            if (pad_idx_ff == LAST_SLOT) begin
               state_in = ST_INIT;
            end else begin
               pad_idx_in = pad_idx_ff + 4'd1;
            end
         end
         ST_INIT: begin
            core_ctl.init = 1'b1;
            wm_ctl.rd_sel = RD_FIRST;
            wm_ctl.rd_idx = 4'd0;
            round_in      = 7'd0;
            state_in      = ST_RD;
         end
         ST_RD: begin
            wm_ctl.cap_x  = 1'b1;
            wm_ctl.rd_sel = RD_SECOND;
            wm_ctl.rd_idx = round_ff[3:0];
            state_in      = ST_EXE;
         end
         ST_EXE: begin
            wm_ctl.exe     = 1'b1;
            wm_ctl.w_idx   = round_ff[3:0];
            wm_ctl.w_sched = (round_ff >= SCHED_START);
            wm_ctl.rd_sel  = RD_FIRST;
            wm_ctl.rd_idx  = round_ff[3:0] + 4'd1;
            core_ctl.exe   = 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FIN;
            end else begin
               round_in = round_ff + 7'd1;
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            core_ctl.fin = 1'b1;
            case (pend_ff)
               PEND_ACCEPT: begin
                  state_in = ST_IDLE;
               end
               PEND_PAD_MARK: begin
                  pad_idx_in = 4'd0;
                  mark_in    = 1'b1;
                  len_in     = 1'b1;
                  pend_in    = PEND_EMIT;
                  state_in   = ST_PAD;
               end
               PEND_PAD_LEN: begin
                  pad_idx_in = 4'd0;
                  mark_in    = 1'b0;
                  len_in     = 1'b1;
                  pend_in    = PEND_EMIT;
                  state_in   = ST_PAD;
               end
               default: begin
                  idx_in   = 3'd0;
                  state_in = ST_CHECK;
               end
            endcase
         end
         ST_CHECK: begin
            core_ctl.chk = 1'b1;
            if (idx_ff == LAST_WORD) begin
               idx_in   = 3'd0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (idx_ff == LAST_WORD) begin
                  cnt_in   = '0;
                  open_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         open_ff  <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff    <= pend_in;
      acc_ff     <= acc_in;
      pad_idx_ff <= pad_idx_in;
      mark_ff    <= mark_in;
      len_ff     <= len_in;
      round_ff   <= round_in;
      idx_ff     <= idx_in;
   end

   assign out_index = idx_ff;
   assign out_last  = (idx_ff == LAST_WORD);

endmodule

[hw/rtl/sha1_variant_digest.sv]
// ----------------------------------------------------------------------------
// sha1_variant_digest
// 80-round sha1-style digest with register iv and altered round constants
// ----------------------------------------------------------------------------
// a byte is accepted only while idle; every 64th byte starts a compression,
// each round a read step then an execute step, set by the two-read-port
// schedule memory; after the last byte: padding, one or two compressions, a
// check of five words, then five result transactions, one per cycle if taken
// on reset the iv and difficulty registers take their default values, control
// returns to idle; other registers and the schedule memory are not cleared
// ----------------------------------------------------------------------------
module sha1_variant_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [3:0]  rsp_tuser,   // word_index [2:0], meets_difficulty [3]
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import sha1v_pkg::*;

   word_type [4:0] iv_ff;
   word_type [4:0] iv_in;
   logic [7:0]     diff_ff;
   logic [7:0]     diff_in;
   wm_ctl_type     wm_ctl;
   core_ctl_type   core_ctl;
   word_type       w;
   word_type       out_word;
   logic           flag;
   logic [2:0]     out_index;

   always_comb begin
      iv_in   = iv_ff;
      diff_in = diff_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_IV0:  iv_in[0] = csr_wdata;
            CSR_IV1:  iv_in[1] = csr_wdata;
            CSR_IV2:  iv_in[2] = csr_wdata;
            CSR_IV3:  iv_in[3] = csr_wdata;
            CSR_IV4:  iv_in[4] = csr_wdata;
            CSR_DIFF: diff_in = csr_wdata[7:0];
            default: begin
               diff_in = diff_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff[0] <= IV0_RESET;
         iv_ff[1] <= IV1_RESET;
         iv_ff[2] <= IV2_RESET;
         iv_ff[3] <= IV3_RESET;
         iv_ff[4] <= IV4_RESET;
         diff_ff  <= DIFF_RESET;
      end else begin
         iv_ff   <= iv_in;
         diff_ff <= diff_in;
      end
   end

   sha1v_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .in_last   (req_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (out_index),
      .out_last  (rsp_tlast),
      .wm_ctl    (wm_ctl),
      .core_ctl  (core_ctl)
   );

   sha1v_wmem u_wmem (
      .clock (clock),
      .ctl   (wm_ctl),
      .w     (w)
   );

   sha1v_core u_core (
      .clock      (clock),
      .ctl        (core_ctl),
      .iv         (iv_ff),
      .difficulty (diff_ff),
      .w          (w),
      .out_word   (out_word),
      .flag       (flag)
   );

   assign rsp_tdata = out_word;
   assign rsp_tuser = {flag, out_index};

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input taken while results pending");

   a_last_is_e: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser[2:0] == LAST_WORD))
      else $error("last flag on a word other than e");

   a_ready_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("not idle after the last digest word");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tvalid && (rsp_tuser[2:0] == $past(rsp_tuser[2:0]) + 3'd1)))
      else $error("digest words out of order");
`endif

endmodule

[tb/sha1_variant_digest_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_variant_digest_checker
// watches the byte, digest and register ports of the digest block, keeps its
// own copy of the iv and difficulty registers, hashes every accepted byte
// stream itself and compares each digest word against the oldest prediction
// ----------------------------------------------------------------------------
module sha1_variant_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // digest_word
   input  logic [3:0]  rsp_tuser,   // word_index [2:0], meets_difficulty [3]
   input  logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          words_due
);
   import sha1v_pkg::*;

   localparam int DIGEST_BITS = 160;

   typedef struct packed {
      logic [2:0] word_index;
      word_type   digest_word;
      logic       meets;
      logic       last_word;
   } digest_rec_type;

   digest_rec_type digest_words_due[$];

   word_type    iv_word[5];
   logic [7:0]  difficulty;
   logic [7:0]  block_bytes[64];
   word_type    chain[5];
   word_type    sched[16];
   logic [28:0] byte_count;
   logic        msg_open;

   function automatic word_type rol(word_type v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   task automatic compress_block();
      word_type a, b, c, d, e, w, f, t;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int j = 0; j < 80; j++) begin
         if (j < 16) begin
            w = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2],
                 block_bytes[4*j+3]};
         end else begin
            w = rol(sched[(j-3) & 15] ^ sched[(j-8) & 15] ^ sched[(j-14) & 15]
                    ^ sched[j & 15], 1);
         end
         sched[j & 15] = w;
         if (j < 20)
            f = ((b & c) | (~b & d)) + K_ROUND0;
         else if (j < 40)
            f = (b ^ c ^ d) + K_ROUND1;
         else if (j < 60)
            f = ((d & c) | (b & (d | c))) + K_ROUND2;
         else
            f = (b ^ c ^ d) + K_ROUND3;
         t = rol(a, 5) + e + w + f;
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endtask

   task automatic clear_block_from(int first);
      for (int i = first; i < 64; i++)
         block_bytes[i] = 8'h00;
   endtask

   task automatic put_bit_count(logic [31:0] bits);
      block_bytes[60] = bits[31:24];
      block_bytes[61] = bits[23:16];
      block_bytes[62] = bits[15:8];
      block_bytes[63] = bits[7:0];
   endtask

   // leading bits taken msb-first from the little-endian bytes of the words
   function automatic logic difficulty_met();
      int       lim;
      int       byte_idx;
      logic [7:0] byte_val;
      lim = (difficulty > DIGEST_BITS) ? DIGEST_BITS : int'(difficulty);
      for (int i = 0; i < lim; i++) begin
         byte_idx = i >> 3;
         byte_val = 8'(chain[(byte_idx >> 2) % 5] >> ((byte_idx & 3) * 8));
         if (byte_val[7 - (i & 7)])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic absorb_byte(logic [7:0] data, logic last);
      int          pos;
      int          rem;
      logic [31:0] bits;
      logic        meets;
      digest_rec_type rec;
      if (!msg_open) begin
         chain = iv_word;
         msg_open = 1'b1;
      end
      pos = int'(byte_count[5:0]);
      block_bytes[pos] = data;
      byte_count = byte_count + 29'd1;
      if (!last) begin
         if (pos == 63)
            compress_block();
      end else begin
         bits = {byte_count, 3'b000};
         rem = int'(byte_count[5:0]);
         if (rem == 0) begin
            // full last block, then a pad block of its own
            compress_block();
            clear_block_from(0);
            block_bytes[0] = PAD_BYTE;
            put_bit_count(bits);
            compress_block();
         end else if (rem <= 56) begin
            block_bytes[rem] = PAD_BYTE;
            clear_block_from(rem + 1);
            put_bit_count(bits);
            compress_block();
         end else begin
            // no room for the length, it goes into an extra block
            block_bytes[rem] = PAD_BYTE;
            clear_block_from(rem + 1);
            compress_block();
            clear_block_from(0);
            put_bit_count(bits);
            compress_block();
         end
         meets = difficulty_met();
         for (int k = 0; k < 5; k++) begin
            rec.word_index  = 3'(k);
            rec.digest_word = chain[k];
            rec.meets       = meets;
            rec.last_word   = (k == 4);
            digest_words_due.push_back(rec);
         end
         byte_count = '0;
         msg_open = 1'b0;
      end
   endtask

   task automatic note_mismatch(string what, logic [31:0] expected, logic [31:0] actual);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %h, got %h at %0t", what, expected, actual,
                  $realtime);
   endtask

   initial begin
      mismatch_count = 0;
      words_due = 0;
   end

   always @(posedge clock) begin
      digest_rec_type exp_rec;
      if (reset) begin
         iv_word[0] = IV0_RESET;
         iv_word[1] = IV1_RESET;
         iv_word[2] = IV2_RESET;
         iv_word[3] = IV3_RESET;
         iv_word[4] = IV4_RESET;
         difficulty = DIFF_RESET;
         byte_count = '0;
         msg_open = 1'b0;
         digest_words_due.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_IV0, CSR_IV1, CSR_IV2, CSR_IV3, CSR_IV4: begin
                  iv_word[csr_index] = csr_wdata;
               end
               CSR_DIFF: begin
                  difficulty = csr_wdata[7:0];
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            absorb_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (digest_words_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected digest word %h index %0d at %0t", rsp_tdata,
                           rsp_tuser[2:0], $realtime);
            end else begin
               exp_rec = digest_words_due.pop_front();
               if (rsp_tuser[2:0] !== exp_rec.word_index)
                  note_mismatch("word_index", 32'(exp_rec.word_index),
                                32'(rsp_tuser[2:0]));
               if (rsp_tdata !== exp_rec.digest_word)
                  note_mismatch("digest_word", exp_rec.digest_word, rsp_tdata);
               if (rsp_tuser[3] !== exp_rec.meets)
                  note_mismatch("meets_difficulty", 32'(exp_rec.meets), 32'(rsp_tuser[3]));
               if (rsp_tlast !== exp_rec.last_word)
                  note_mismatch("last_word", 32'(exp_rec.last_word), 32'(rsp_tlast));
            end
         end
      end
      words_due = digest_words_due.size();
   end

endmodule

[tb/tb_sha1_variant_digest.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_variant_digest
// drives byte streams, register writes and back-pressure into the digest
// block; short directed messages first, then random messages whose lengths
// cluster around the padding boundaries, under three idling patterns
// ----------------------------------------------------------------------------
module tb_sha1_variant_digest;
   import sha1v_pkg::*;

   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES   = 1000;
   localparam int QUIET_LIMIT   = 6000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   int   mismatch_count;
   int   words_due;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   quiet_cycles = 0;
   logic hold_armed = 1'b0;
   logic holding = 1'b0;

   sha1_variant_digest u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sha1_variant_digest_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // receiver
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= !holding && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (hold_armed);
      @(negedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[sha1_variant_digest] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(logic [7:0] data, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(255)), i == len - 1);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic configure(word_type w0, word_type w1, word_type w2, word_type w3,
                            word_type w4, logic [31:0] diff);
      write_reg(CSR_IV0, w0);
      write_reg(CSR_IV1, w1);
      write_reg(CSR_IV2, w2);
      write_reg(CSR_IV3, w3);
      write_reg(CSR_IV4, w4);
      write_reg(CSR_DIFF, diff);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int          len;
      int          phase_items;
      logic [31:0] diff;
      word_type    iv_pick[5];

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values of the registers, single-byte messages at both extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_message(2);

      settle();
      configure('0, '0, '0, '0, '0, 32'd0);
      send_message(3);

      // difficulty above the digest width
      settle();
      configure('1, '1, '1, '1, '1, 32'd255);
      send_byte(8'ha5, 1'b1);

      settle();
      configure($urandom, $urandom, $urandom, $urandom, $urandom, 32'd160);
      send_message(2);

      // iv rewritten mid-message only applies to the next message
      settle();
      configure($urandom, $urandom, $urandom, $urandom, $urandom, 32'd1);
      for (int i = 0; i < 5; i++)
         send_byte(8'($urandom_range(255)), 1'b0);
      settle();
      configure($urandom, $urandom, $urandom, $urandom, $urandom, 32'hffff_ff02);
      for (int i = 0; i < 4; i++)
         send_byte(8'($urandom_range(255)), i == 3);
      send_message(1);

      for (int phase = 0; phase < 3; phase++) begin
         settle();
         case (phase)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if ($urandom_range(1) == 0) begin
            iv_pick[0] = IV0_RESET;
            iv_pick[1] = IV1_RESET;
            iv_pick[2] = IV2_RESET;
            iv_pick[3] = IV3_RESET;
            iv_pick[4] = IV4_RESET;
         end else begin
            for (int k = 0; k < 5; k++)
               iv_pick[k] = $urandom;
         end
         case ($urandom_range(5))
            0: diff = 0;
            1: diff = 1;
            2: diff = 2;
            3: diff = 160;
            4: diff = 255;
            default: diff = $urandom_range(255);
         endcase
         configure(iv_pick[0], iv_pick[1], iv_pick[2], iv_pick[3], iv_pick[4], diff);
         if (phase == 2)
            hold_armed <= 1'b1;
         phase_items = 0;
         while (phase_items < 36) begin
            case ($urandom_range(7))
               0, 1, 2, 3: len = $urandom_range(1, 12);
               4, 5: begin
                  case ($urandom_range(10))
                     0: len = 55;
                     1: len = 56;
                     2: len = 57;
                     3: len = 60;
                     4: len = 63;
                     5: len = 64;
                     6: len = 65;
                     7: len = 119;
                     8: len = 120;
                     9: len = 121;
                     default: len = 128;
                  endcase
               end
               default: len = $urandom_range(1, 80);
            endcase
            send_message(len);
            phase_items += len;
         end
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (words_due != 0)
         $display("digest words never delivered: %0d", words_due);
      if (mismatch_count == 0 && words_due == 0)
         $display("[sha1_variant_digest] OK");
      else
         $display("[sha1_variant_digest] ERROR");
      $finish;
   end

endmodule
